// File: rtl/trs_pkg.sv
//------------------------------------------------------------------------------
// trs_pkg
// Shared types, constants and tables for the affine matrix builder.
//------------------------------------------------------------------------------
package trs_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int FRAC_BITS    = 16;

  localparam int ANG_W   = 17;
  localparam int POS_W   = 32;
  localparam int TRIG_W  = 34;   // cordic datapath, Q2.30 plus guard
  localparam int FR_W    = FRAC_BITS + 3; // trig value width in FRAC_BITS

  localparam logic signed [17:0] ANG_FULL    = 18'sd46080;
  localparam logic signed [17:0] ANG_HALF    = 18'sd23040;
  localparam logic signed [17:0] ANG_QUARTER = 18'sd11520;
  localparam logic signed [17:0] ANG_THREEQ  = 18'sd34560;
  localparam logic signed [18:0] RAD_PER_UNIT_Q30 = 19'sd146409;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = TRIG_W'(32'h26DD3B6A);

  localparam int IN_W  = 3 * POS_W + 3 * ANG_W + 3 * POS_W;
  localparam int IN_TW = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W = 12 * POS_W;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [ANG_W-1:0] ang_x;
    logic signed [ANG_W-1:0] ang_y;
    logic signed [ANG_W-1:0] ang_z;
    logic signed [POS_W-1:0] scl_x;
    logic signed [POS_W-1:0] scl_y;
    logic signed [POS_W-1:0] scl_z;
  } item_t;

  // folded angle and sign flag for one axis
  typedef struct packed {
    logic signed [17:0] th;
    logic               neg;
  } fold_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    fold_t                   fx;
    fold_t                   fy;
    fold_t                   fz;
    logic signed [POS_W-1:0] scl_x;
    logic signed [POS_W-1:0] scl_y;
    logic signed [POS_W-1:0] scl_z;
  } cls_t;

  function automatic logic signed [TRIG_W-1:0] atan_q30(input int k);
    logic [31:0] t;
    unique case (k)
      0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
      18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
      21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
      24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
      27: t = 32'h00000008; 28: t = 32'h00000004; 29: t = 32'h00000002;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return TRIG_W'(t);
  endfunction

  // round half up then arithmetic shift by FRAC_BITS
  function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v + (64'sd1 <<< (FRAC_BITS - 1));
    return r >>> FRAC_BITS;
  endfunction

endpackage

// File: rtl/trs_euler_matrix_builder.sv
//------------------------------------------------------------------------------
// trs_euler_matrix_builder
// Builds the upper three rows of T*Rz*Ry*Rx*S from position, angles, scale.
//------------------------------------------------------------------------------
// Input stream s_axis: one beat per transform, tdata packs pos_x, pos_y,
// pos_z, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z.
// Output stream m_axis: one beat per transform, tdata packs the twelve
// matrix entries row by row, m_r0_c0 in the low 32 bits.
// Throughput: one transform per cycle while m_axis is not stalled; the
// CORDIC is unrolled into one stage per iteration and all products run
// in parallel lanes. A transform passes one classify stage, the queue,
// the CORDIC stages and five arithmetic stages.
// When the receiver stalls the back pipeline freezes, the queue fills and
// then s_axis_tready drops. Reset empties every stage and the queue.
//------------------------------------------------------------------------------
module trs_euler_matrix_builder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z
  input  logic [trs_pkg::IN_TW-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // m_r0_c0 .. m_r0_c3, m_r1_c0 .. m_r1_c3, m_r2_c0 .. m_r2_c3
  output logic [trs_pkg::OUT_W-1:0]  m_axis_tdata
);
  import trs_pkg::*;

  item_t in_item;
  cls_t  f_item, q_item;
  logic  f_valid, f_ready, q_valid, q_ready;

  assign in_item.pos_x = s_axis_tdata[31:0];
  assign in_item.pos_y = s_axis_tdata[63:32];
  assign in_item.pos_z = s_axis_tdata[95:64];
  assign in_item.ang_x = s_axis_tdata[112:96];
  assign in_item.ang_y = s_axis_tdata[129:113];
  assign in_item.ang_z = s_axis_tdata[146:130];
  assign in_item.scl_x = s_axis_tdata[178:147];
  assign in_item.scl_y = s_axis_tdata[210:179];
  assign in_item.scl_z = s_axis_tdata[242:211];

  trs_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item,
    .cls_valid(f_valid), .cls_ready(f_ready), .cls_item(f_item)
  );

  trs_fifo u_fifo (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_item)
  );

  trs_back u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid && !f_valid)
    else $error("pipeline not empty after reset");
  a_fifo: assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_ready |-> q_valid)
    else $error("queue full but reads empty");
endmodule

// File: rtl/trs_front.sv
//------------------------------------------------------------------------------
// trs_front
// Accept input beats, wrap each angle into one turn and fold to a half turn.
//------------------------------------------------------------------------------
module trs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  trs_pkg::item_t       in_item,
  output logic                 cls_valid,
  input  logic                 cls_ready,
  output trs_pkg::cls_t        cls_item
);
  import trs_pkg::*;

  function automatic fold_t fold(input logic signed [ANG_W-1:0] a);
    logic signed [17:0] w;
    fold_t f;
    w = 18'(a);
    // two corrections bring any 17 bit value into one turn
    if (w < 0) w = w + ANG_FULL;
    if (w < 0) w = w + ANG_FULL;
    if (w >= ANG_FULL) w = w - ANG_FULL;
    if (w >= ANG_FULL) w = w - ANG_FULL;
    f.neg = 1'b0;
    if (w <= ANG_QUARTER) f.th = w;
    else if (w < ANG_THREEQ) begin
      f.th = w - ANG_HALF;
      f.neg = 1'b1;
    end else f.th = w - ANG_FULL;
    return f;
  endfunction

  assign in_ready = !cls_valid || cls_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (in_ready) begin
      cls_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cls_item.pos_x <= in_item.pos_x;
      cls_item.pos_y <= in_item.pos_y;
      cls_item.pos_z <= in_item.pos_z;
      cls_item.fx    <= fold(in_item.ang_x);
      cls_item.fy    <= fold(in_item.ang_y);
      cls_item.fz    <= fold(in_item.ang_z);
      cls_item.scl_x <= in_item.scl_x;
      cls_item.scl_y <= in_item.scl_y;
      cls_item.scl_z <= in_item.scl_z;
    end
  end
endmodule

// File: rtl/trs_fifo.sv
//------------------------------------------------------------------------------
// trs_fifo
// Two-entry queue between the front and the back.
//------------------------------------------------------------------------------
module trs_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  trs_pkg::cls_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output trs_pkg::cls_t rd_data
);
  import trs_pkg::*;

  cls_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

// File: rtl/trs_back.sv
//------------------------------------------------------------------------------
// trs_back
// Pipelined CORDIC, trig products and scaling, one item per cycle unless the output stalls.
//------------------------------------------------------------------------------
module trs_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  trs_pkg::cls_t                  in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [trs_pkg::OUT_W-1:0]      out_data
);
  import trs_pkg::*;

  localparam int NST = CORDIC_STEPS + 5;
  localparam int P   = CORDIC_STEPS; // stage of the last cordic step

  typedef logic signed [TRIG_W-1:0] tw_t;
  typedef logic signed [FR_W-1:0]   fr_t;
  typedef logic signed [POS_W-1:0]  w_t;

  logic      adv;
  logic      vld [1:NST];
  cls_t      itm [1:NST];
  tw_t       cx [3][1:CORDIC_STEPS];
  tw_t       cy [3][1:CORDIC_STEPS];
  tw_t       cz [3][1:CORDIC_STEPS];
  fr_t       sn [3], cs [3];
  fr_t       sysx, sycx, czcy, szcy, cysx, cycx, nsy;
  fr_t       czsx, szsx, czcx, szcx;
  fr_t       e01, e11;
  fr_t       ent [9];
  logic signed [FR_W+POS_W-1:0] prd [9];
  w_t        res [9];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  function automatic fold_t fsel(input cls_t c, input int a);
    fold_t f;
    unique case (a)
      0: f = c.fx;
      1: f = c.fy;
      default: f = c.fz;
    endcase
    return f;
  endfunction

  function automatic fr_t trnd(input tw_t v, input logic neg);
    tw_t n;
    tw_t r;
    n = neg ? -v : v;
    r = (n + (tw_t'(1) <<< (30 - FRAC_BITS - 1))) >>> (30 - FRAC_BITS);
    return FR_W'(r);
  endfunction

  function automatic fr_t mr(input fr_t a, input fr_t b);
    logic signed [2*FR_W-1:0] p;
    p = a * b;
    return FR_W'(rnd_frac(64'(p)));
  endfunction

  function automatic w_t sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return POS_W'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= NST; s++) vld[s] <= 1'b0;
    end else if (adv) begin
      vld[1] <= in_valid;
      for (int s = 2; s <= NST; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      itm[1] <= in_item;
      for (int s = 2; s <= NST; s++) itm[s] <= itm[s-1];
    end
  end

  // cordic: step i reads the input for i == 0, else stage i
  for (genvar a = 0; a < 3; a++) begin : g_ax
    fold_t              f_in, f_p;
    logic signed [36:0] z_prod;
    assign f_in   = fsel(in_item, a);
    assign f_p    = fsel(itm[P], a);
    assign z_prod = f_in.th * RAD_PER_UNIT_Q30;
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_st
      tw_t xi, yi, zi;
      if (i == 0) begin : g_ld
        assign xi = CORDIC_GAIN_Q30;
        assign yi = '0;
        assign zi = TRIG_W'(z_prod);
      end else begin : g_nx
        assign xi = cx[a][i];
        assign yi = cy[a][i];
        assign zi = cz[a][i];
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          if (zi >= 0) begin
            cx[a][i+1] <= xi - (yi >>> (i % 32));
            cy[a][i+1] <= yi + (xi >>> (i % 32));
            cz[a][i+1] <= zi - atan_q30(i % 32);
          end else begin
            cx[a][i+1] <= xi + (yi >>> (i % 32));
            cy[a][i+1] <= yi - (xi >>> (i % 32));
            cz[a][i+1] <= zi + atan_q30(i % 32);
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cs[a] <= trnd(cx[a][CORDIC_STEPS], f_p.neg);
        sn[a] <= trnd(cy[a][CORDIC_STEPS], f_p.neg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sysx <= mr(sn[1], sn[0]);
      sycx <= mr(sn[1], cs[0]);
      czcy <= mr(cs[2], cs[1]);
      szcy <= mr(sn[2], cs[1]);
      cysx <= mr(cs[1], sn[0]);
      cycx <= mr(cs[1], cs[0]);
      nsy  <= -sn[1];
      czsx <= mr(cs[2], sn[0]);
      szsx <= mr(sn[2], sn[0]);
      czcx <= mr(cs[2], cs[0]);
      szcx <= mr(sn[2], cs[0]);
      e01  <= cs[2];
      e11  <= sn[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent[0] <= czcy;
      ent[1] <= mr(e01, sysx) - szcx;
      ent[2] <= mr(e01, sycx) + szsx;
      ent[3] <= szcy;
      ent[4] <= mr(e11, sysx) + czcx;
      ent[5] <= mr(e11, sycx) - czsx;
      ent[6] <= nsy;
      ent[7] <= cysx;
      ent[8] <= cycx;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        unique case (k % 3)
          0: prd[k] <= ent[k] * itm[P+3].scl_x;
          1: prd[k] <= ent[k] * itm[P+3].scl_y;
          default: prd[k] <= ent[k] * itm[P+3].scl_z;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) res[k] <= sat(rnd_frac(64'(prd[k])));
    end
  end

  assign out_valid = vld[NST];
  assign out_data = {itm[NST].pos_z, res[8], res[7], res[6],
                     itm[NST].pos_y, res[5], res[4], res[3],
                     itm[NST].pos_x, res[2], res[1], res[0]};
endmodule
